[hdl/fsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame send pacer package
// Shared widths, constants, the nominal frame interval table and the
// request and response types of the shared divider.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int MAX_FPS = 64;
    localparam int RING_AW = $clog2(MAX_FPS);

    localparam int FPS_W   = 7;
    localparam int KBPS_W  = 20;
    localparam int BYTES_W = 24;
    localparam int TICKS_W = 32;
    localparam int FTIME_W = 40;
    localparam int DELAY_W = 32;
    localparam int BPS_W   = 31;
    localparam int SUM_W   = 30;
    localparam int ACC_W   = 40;
    localparam int LAG_W   = 48;
    localparam int IVL_W   = 24;
    localparam int DIV_W   = 40;
    localparam int STEP_W  = 6;
    localparam int CFG_W   = 20;

    localparam logic [FPS_W-1:0]  FPS_RESET  = 7'd30;
    localparam logic [KBPS_W-1:0] KBPS_RESET = 20'd1000;

    localparam logic CFG_FPS  = 1'b0;
    localparam logic CFG_KBPS = 1'b1;

    localparam logic [ACC_W-1:0]  TICKS_PER_SEC = 40'd10000000;
    localparam logic [16:0]       PACE_SCALE    = 17'd80000;
    localparam logic [16:0]       RATE_SCALE    = 17'd78125;
    localparam logic [LAG_W-1:0]  START_LAG     = 48'd10000;
    localparam logic [STEP_W-1:0] FRAME_STEPS   = 6'd40;
    localparam logic [STEP_W-1:0] RATE_STEPS    = 6'd31;

    localparam logic [IVL_W-1:0] NOMINAL_TICKS [MAX_FPS] = '{
        24'd10000000, 24'd5000000, 24'd3333333, 24'd2500000,
        24'd2000000,  24'd1666666, 24'd1428571, 24'd1250000,
        24'd1111111,  24'd1000000, 24'd909090,  24'd833333,
        24'd769230,   24'd714285,  24'd666666,  24'd625000,
        24'd588235,   24'd555555,  24'd526315,  24'd500000,
        24'd476190,   24'd454545,  24'd434782,  24'd416666,
        24'd400000,   24'd384615,  24'd370370,  24'd357142,
        24'd344827,   24'd333333,  24'd322580,  24'd312500,
        24'd303030,   24'd294117,  24'd285714,  24'd277777,
        24'd270270,   24'd263157,  24'd256410,  24'd250000,
        24'd243902,   24'd238095,  24'd232558,  24'd227272,
        24'd222222,   24'd217391,  24'd212765,  24'd208333,
        24'd204081,   24'd200000,  24'd196078,  24'd192307,
        24'd188679,   24'd185185,  24'd181818,  24'd178571,
        24'd175438,   24'd172413,  24'd169491,  24'd166666,
        24'd163934,   24'd161290,  24'd158730,  24'd156250
    };

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

[hdl/fsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame send pacer channels
// Valid/ready channels for sent frames and for pacing results.
// ----------------------------------------------------------------------------
interface fsp_in_if;
    logic                         valid;
    logic                         ready;
    logic [fsp_pkg::BYTES_W-1:0] frame_bytes;
    logic [fsp_pkg::TICKS_W-1:0] elapsed_ticks;

    modport source (output valid, output frame_bytes, output elapsed_ticks, input ready);
    modport sink (input valid, input frame_bytes, input elapsed_ticks, output ready);
endinterface

interface fsp_out_if;
    logic                         valid;
    logic                         ready;
    logic [fsp_pkg::FTIME_W-1:0] frame_ticks;
    logic [fsp_pkg::DELAY_W-1:0] send_delay;
    logic [fsp_pkg::BPS_W-1:0]   measured_bps;

    modport source (output valid, output frame_ticks, output send_delay,
                    output measured_bps, input ready);
    modport sink (input valid, input frame_ticks, input send_delay,
                  input measured_bps, output ready);
endinterface

[hdl/fsp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame send pacer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsp_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  fsp_pkg::div_req_t req,
    output fsp_pkg::div_rsp_t rsp
);

    logic [fsp_pkg::DIV_W-1:0]  rem_reg;
    logic [fsp_pkg::DIV_W-1:0]  num_reg;
    logic [fsp_pkg::DIV_W-1:0]  dsr_reg;
    logic [fsp_pkg::DIV_W-1:0]  quo_reg;
    logic [fsp_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [fsp_pkg::DIV_W+1:0]  trial;
    logic                       fits;
    logic [fsp_pkg::DIV_W-1:0]  rem_next;

    assign trial    = {1'b0, rem_reg, num_reg[fsp_pkg::DIV_W-1]} - {2'b00, dsr_reg};
    assign fits     = !trial[fsp_pkg::DIV_W+1];
    assign rem_next = fits ? trial[fsp_pkg::DIV_W-1:0]
                           : {rem_reg[fsp_pkg::DIV_W-2:0], num_reg[fsp_pkg::DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == fsp_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            num_reg <= req.num;
            dsr_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[fsp_pkg::DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[fsp_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[hdl/frame_send_pacer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame send pacer
// Paces video frames from a sliding window of frame sizes, tracks the send
// lag and keeps a smoothed measure of the achieved bit rate.
// ----------------------------------------------------------------------------
// One item is handled at a time and the frame port is not ready until its
// result has been placed in the output register. The shared radix-2 divider
// produces one quotient bit per cycle. It computes the paced frame time once
// the size window is full, unless that time would overflow, and the measured
// rate when a one-second rate window closes, unless that rate would overflow.
// A result may wait at the output while the next item is being worked on, and
// that item then holds in its last step until the output register is free.
module frame_send_pacer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [fsp_pkg::CFG_W-1:0]   cfg_data,
    fsp_in_if.sink                      frame,
    fsp_out_if.source                   pacing
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_FCHK   = 4'd3;
    localparam logic [3:0] S_FDIV   = 4'd4;
    localparam logic [3:0] S_RATE   = 4'd5;
    localparam logic [3:0] S_RDIV   = 4'd6;
    localparam logic [3:0] S_SMOOTH = 4'd7;
    localparam logic [3:0] S_LAG    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [fsp_pkg::FPS_W-1:0]   fps_reg;
    logic [fsp_pkg::KBPS_W-1:0]  kbps_reg;
    logic [fsp_pkg::FPS_W-1:0]   ring_pos_reg;
    logic [fsp_pkg::FPS_W-1:0]   fill_count_reg;
    logic [fsp_pkg::SUM_W-1:0]   window_sum_reg;
    logic [fsp_pkg::ACC_W-1:0]   rate_bytes_reg;
    logic [fsp_pkg::ACC_W-1:0]   rate_ticks_reg;
    logic [fsp_pkg::LAG_W-1:0]   due_lag_reg;
    logic [fsp_pkg::BPS_W-1:0]   smoothed_reg;
    logic                        fill_reg;
    logic                        out_valid_reg;

    logic [fsp_pkg::BYTES_W-1:0] bytes_reg;
    logic [fsp_pkg::TICKS_W-1:0] elapsed_reg;
    logic [fsp_pkg::BYTES_W-1:0] rd_data_reg;
    logic [46:0]                 pace_prod_reg;
    logic [26:0]                 pace_div_reg;
    logic [56:0]                 rate_prod_reg;
    logic [fsp_pkg::FTIME_W-1:0] ftime_reg;
    logic [fsp_pkg::BPS_W-1:0]   inst_bps_reg;
    logic [fsp_pkg::FTIME_W-1:0] frame_ticks_reg;
    logic [fsp_pkg::DELAY_W-1:0] send_delay_reg;
    logic [fsp_pkg::BPS_W-1:0]   measured_bps_reg;

    logic [fsp_pkg::BYTES_W-1:0] ring [fsp_pkg::MAX_FPS];

    logic [fsp_pkg::FPS_W-1:0]   eff_fps;
    logic [fsp_pkg::KBPS_W-1:0]  eff_kbps;
    logic [fsp_pkg::IVL_W-1:0]   interval;
    logic [fsp_pkg::FTIME_W-1:0] interval_ext;
    logic                        filling;
    logic [fsp_pkg::RING_AW-1:0] ring_addr;
    logic                        accept;
    logic                        cfg_fps_write;
    logic                        lag_go;
    logic                        rate_due;
    logic                        pace_sat;
    logic                        rate_sat;

    logic [fsp_pkg::ACC_W:0]     bytes_sum;
    logic [fsp_pkg::ACC_W:0]     ticks_sum;
    logic [fsp_pkg::SUM_W:0]     sum_next;
    logic [46:0]                 pace_prod;
    logic [26:0]                 pace_div;
    logic [56:0]                 rate_prod;
    logic [33:0]                 smooth_sum;
    logic [49:0]                 lag_sum;
    logic [fsp_pkg::LAG_W-1:0]   lag_sat;
    logic [fsp_pkg::DELAY_W-1:0] delay;

    fsp_pkg::div_req_t div_req;
    fsp_pkg::div_rsp_t div_rsp;

    assign eff_fps  = (fps_reg == '0) ? fsp_pkg::FPS_W'(1)
                    : (fps_reg > fsp_pkg::FPS_W'(fsp_pkg::MAX_FPS))
                        ? fsp_pkg::FPS_W'(fsp_pkg::MAX_FPS) : fps_reg;
    assign eff_kbps = (kbps_reg == '0) ? fsp_pkg::KBPS_W'(1) : kbps_reg;
    assign interval = fsp_pkg::NOMINAL_TICKS[fsp_pkg::RING_AW'(eff_fps - 1'b1)];
    assign interval_ext = fsp_pkg::FTIME_W'(interval);
    assign filling  = fill_count_reg < eff_fps;
    assign ring_addr = (!filling && ring_pos_reg >= eff_fps) ? '0
                     : ring_pos_reg[fsp_pkg::RING_AW-1:0];

    assign accept        = frame.valid && frame.ready;
    assign cfg_fps_write = cfg_write && (cfg_index == fsp_pkg::CFG_FPS);
    assign lag_go        = !out_valid_reg || pacing.ready;
    assign rate_due      = rate_ticks_reg >= fsp_pkg::TICKS_PER_SEC;
    assign pace_sat      = 27'(pace_prod_reg[46:40]) >= pace_div_reg;
    assign rate_sat      = fsp_pkg::ACC_W'(rate_prod_reg[56:21]) >= rate_ticks_reg;

    assign bytes_sum = {1'b0, rate_bytes_reg} + (fsp_pkg::ACC_W+1)'(frame.frame_bytes);
    assign ticks_sum = {1'b0, rate_ticks_reg} + (fsp_pkg::ACC_W+1)'(frame.elapsed_ticks);
    assign sum_next  = filling
        ? {1'b0, window_sum_reg} + (fsp_pkg::SUM_W+1)'(bytes_reg)
        : {1'b0, window_sum_reg} + (fsp_pkg::SUM_W+1)'(bytes_reg)
          - (fsp_pkg::SUM_W+1)'(rd_data_reg);

    assign pace_prod  = window_sum_reg * fsp_pkg::PACE_SCALE;
    assign pace_div   = eff_fps * eff_kbps;
    assign rate_prod  = rate_bytes_reg * fsp_pkg::RATE_SCALE;
    assign smooth_sum = {3'b000, smoothed_reg} + {2'b00, smoothed_reg, 1'b0}
                      + {3'b000, inst_bps_reg};

    assign lag_sum = {{2{due_lag_reg[fsp_pkg::LAG_W-1]}}, due_lag_reg}
                   + {10'b0, ftime_reg} - {18'b0, elapsed_reg};

    always_comb
    begin
        if (lag_sum[49:47] == 3'b000 || lag_sum[49:47] == 3'b111)
        begin
            lag_sat = lag_sum[fsp_pkg::LAG_W-1:0];
        end
        else if (!lag_sum[49])
        begin
            lag_sat = {1'b0, {(fsp_pkg::LAG_W-1){1'b1}}};
        end
        else
        begin
            lag_sat = {1'b1, {(fsp_pkg::LAG_W-1){1'b0}}};
        end

        if (lag_sat[fsp_pkg::LAG_W-1] || lag_sat == '0)
        begin
            delay = '0;
        end
        else if (lag_sat[fsp_pkg::LAG_W-2:fsp_pkg::DELAY_W] != '0)
        begin
            delay = '1;
        end
        else
        begin
            delay = lag_sat[fsp_pkg::DELAY_W-1:0];
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        if (state_reg == S_FCHK)
        begin
            div_req.start    = !pace_sat;
            div_req.steps    = fsp_pkg::FRAME_STEPS;
            div_req.rem_init = fsp_pkg::DIV_W'(pace_prod_reg[46:40]);
            div_req.num      = pace_prod_reg[39:0];
            div_req.divisor  = fsp_pkg::DIV_W'(pace_div_reg);
        end
        else
        begin
            div_req.start    = (state_reg == S_RATE) && rate_due && !rate_sat;
            div_req.steps    = fsp_pkg::RATE_STEPS;
            div_req.rem_init = fsp_pkg::DIV_W'(rate_prod_reg[56:21]);
            div_req.num      = {rate_prod_reg[20:0], 19'b0};
            div_req.divisor  = rate_ticks_reg;
        end
    end

    fsp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = accept ? S_SUM : S_IDLE;
            S_SUM:    state_next = S_MUL;
            S_MUL:    state_next = fill_reg ? S_RATE : S_FCHK;
            S_FCHK:   state_next = pace_sat ? S_RATE : S_FDIV;
            S_FDIV:   state_next = div_rsp.done ? S_RATE : S_FDIV;
            S_RATE:   state_next = !rate_due ? S_LAG : (rate_sat ? S_SMOOTH : S_RDIV);
            S_RDIV:   state_next = div_rsp.done ? S_SMOOTH : S_RDIV;
            S_SMOOTH: state_next = S_LAG;
            S_LAG:    state_next = lag_go ? S_IDLE : S_LAG;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fps_reg        <= fsp_pkg::FPS_RESET;
            kbps_reg       <= fsp_pkg::KBPS_RESET;
            ring_pos_reg   <= '0;
            fill_count_reg <= '0;
            window_sum_reg <= '0;
            rate_bytes_reg <= '0;
            rate_ticks_reg <= '0;
            due_lag_reg    <= fsp_pkg::START_LAG;
            smoothed_reg   <= '0;
            fill_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && cfg_index == fsp_pkg::CFG_KBPS)
            begin
                kbps_reg <= cfg_data;
            end

            if (cfg_fps_write)
            begin
                fps_reg        <= cfg_data[fsp_pkg::FPS_W-1:0];
                ring_pos_reg   <= '0;
                fill_count_reg <= '0;
                window_sum_reg <= '0;
            end
            else if (state_reg == S_SUM)
            begin
                window_sum_reg <= sum_next[fsp_pkg::SUM_W-1:0];
                ring_pos_reg   <= fsp_pkg::FPS_W'(ring_addr) + 1'b1;
                if (filling)
                begin
                    fill_count_reg <= fill_count_reg + 1'b1;
                end
            end

            if (state_reg == S_SUM)
            begin
                fill_reg <= filling;
            end

            if (accept)
            begin
                rate_bytes_reg <= bytes_sum[fsp_pkg::ACC_W] ? '1
                                                            : bytes_sum[fsp_pkg::ACC_W-1:0];
                rate_ticks_reg <= ticks_sum[fsp_pkg::ACC_W] ? '1
                                                            : ticks_sum[fsp_pkg::ACC_W-1:0];
            end
            else if (state_reg == S_SMOOTH)
            begin
                smoothed_reg   <= smooth_sum[fsp_pkg::BPS_W+1:2];
                rate_bytes_reg <= '0;
                rate_ticks_reg <= '0;
            end

            if (state_reg == S_LAG && lag_go)
            begin
                due_lag_reg   <= lag_sat;
                out_valid_reg <= 1'b1;
            end
            else if (pacing.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg   <= frame.frame_bytes;
            elapsed_reg <= frame.elapsed_ticks;
        end

        if (state_reg == S_MUL)
        begin
            pace_prod_reg <= pace_prod;
            pace_div_reg  <= pace_div;
            rate_prod_reg <= rate_prod;
            if (fill_reg)
            begin
                ftime_reg <= interval_ext;
            end
        end

        if (state_reg == S_FCHK && pace_sat)
        begin
            ftime_reg <= '1;
        end

        if (state_reg == S_FDIV && div_rsp.done)
        begin
            ftime_reg <= (div_rsp.quo < interval_ext) ? interval_ext : div_rsp.quo;
        end

        if (state_reg == S_RATE && rate_due && rate_sat)
        begin
            inst_bps_reg <= '1;
        end

        if (state_reg == S_RDIV && div_rsp.done)
        begin
            inst_bps_reg <= div_rsp.quo[fsp_pkg::BPS_W-1:0];
        end

        if (state_reg == S_LAG && lag_go)
        begin
            frame_ticks_reg  <= ftime_reg;
            send_delay_reg   <= delay;
            measured_bps_reg <= smoothed_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            ring[ring_addr] <= bytes_reg;
        end
        rd_data_reg <= ring[ring_addr];
    end

    assign frame.ready         = (state_reg == S_IDLE);
    assign pacing.valid        = out_valid_reg;
    assign pacing.frame_ticks  = frame_ticks_reg;
    assign pacing.send_delay   = send_delay_reg;
    assign pacing.measured_bps = measured_bps_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !frame.ready)
        else $error("frame port ready right after an accepted item");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= eff_fps)
        else $error("window fill count beyond the frame rate");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LAG))
        else $error("result raised outside the lag update");

endmodule

[bench/frame_send_pacer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame send pacer testbench
// Sends frames through the valid/ready channel and changes the frame rate and
// the bandwidth between runs. Each result is checked against a cycle-free
// model of the window sum, send lag and rate smoothing (typed script rows:
// against their given result). A short scripted sequence covers the extremes
// first. Random runs have random gaps on both channels and long output stalls.
// ----------------------------------------------------------------------------
module frame_send_pacer_tb;

    typedef struct packed {
        logic [fsp_pkg::FTIME_W-1:0] frame_ticks;
        logic [fsp_pkg::DELAY_W-1:0] send_delay;
        logic [fsp_pkg::BPS_W-1:0]   measured_bps;
    } pacing_t;

    typedef enum logic [1:0] {ROW_FRAME, ROW_FPS, ROW_KBPS} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [fsp_pkg::BYTES_W-1:0] bytes;
        logic [fsp_pkg::TICKS_W-1:0] ticks;
        logic [fsp_pkg::CFG_W-1:0]   value;
        logic                        typed;
        pacing_t                     result;
    } row_t;

    typedef enum logic [1:0] {TICK_PACED, TICK_BURST, TICK_ANY} tick_law_t;

    typedef struct packed {
        logic [fsp_pkg::FPS_W-1:0]   fps;
        logic [fsp_pkg::KBPS_W-1:0]  kbps;
        logic                        kbps_random;
        logic [15:0]                 frames;
        logic [fsp_pkg::BYTES_W-1:0] bytes_lo;
        logic [fsp_pkg::BYTES_W-1:0] bytes_hi;
        tick_law_t                   law;
    } run_t;

    localparam longint unsigned SEC_TICKS    = 64'd10000000;
    localparam longint unsigned FRAME_SCALE  = 64'd80000;
    localparam longint unsigned BIT_SCALE    = 64'd80000000;
    localparam longint unsigned FTIME_LIMIT  = 64'h00FF_FFFF_FFFF;
    localparam longint unsigned ACC_LIMIT    = 64'h00FF_FFFF_FFFF;
    localparam longint unsigned RATE_LIMIT   = 64'h7FFF_FFFF;
    localparam longint          LAG_HI       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          LAG_LO       = -LAG_HI - 64'sd1;
    localparam longint          DELAY_LIMIT  = 64'sh0000_0000_FFFF_FFFF;
    localparam longint          LAG_START    = 64'sd10000;

    localparam int GAP_MAX      = 18;
    localparam int STALL_AT_A   = 25;
    localparam int STALL_AT_B   = 200;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 120;

    localparam pacing_t NO_RESULT = '0;

    localparam row_t SCRIPT [15] = '{
        '{ROW_FRAME, 24'd0,        32'd0,          20'd0, 1'b1,
          '{40'd333333, 32'd343333, 31'd0}},
        '{ROW_FRAME, 24'd0,        32'd0,          20'd0, 1'b1,
          '{40'd333333, 32'd676666, 31'd0}},
        '{ROW_FRAME, 24'hFFFFFF,   32'hFFFFFFFF,   20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'hA5A5A5,   32'd1,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'h5A5A5A,   32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FPS,   24'd0,        32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_KBPS,  24'd0,        32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'd0,        32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'd1,        32'd500,        20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'd53687,    32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'd3,        32'd2000000,    20'd0, 1'b0, NO_RESULT},
        '{ROW_FPS,   24'd0,        32'd0,          20'd127, 1'b0, NO_RESULT},
        '{ROW_KBPS,  24'd0,        32'd0,          20'd1000000, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'hFFFFFF,   32'd0,          20'd0, 1'b0, NO_RESULT},
        '{ROW_FRAME, 24'd0,        32'h0000FFFF,   20'd0, 1'b0, NO_RESULT}
    };

    localparam run_t RUNS [5] = '{
        '{7'd30,  20'd1000,    1'b0, 16'd90,  24'd0,       24'd200000,  TICK_PACED},
        '{7'd1,   20'd1000000, 1'b0, 16'd40,  24'd0,       24'hFFFFFF,  TICK_PACED},
        '{7'd65,  20'd0,       1'b1, 16'd90,  24'd0,       24'd65535,   TICK_PACED},
        '{7'd64,  20'd1000000, 1'b0, 16'd80,  24'hF00000,  24'hFFFFFF,  TICK_BURST},
        '{7'd0,   20'd1,       1'b0, 16'd160, 24'hC00000,  24'hFFFFFF,  TICK_ANY}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic                      cfg_index;
    logic [fsp_pkg::CFG_W-1:0] cfg_data;

    fsp_in_if  frame_ch ();
    fsp_out_if pacing_ch ();

    frame_send_pacer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .pacing    (pacing_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [fsp_pkg::FPS_W-1:0]   fps_reg;
    logic [fsp_pkg::KBPS_W-1:0]  kbps_reg;
    logic [fsp_pkg::BYTES_W-1:0] size_hist [fsp_pkg::MAX_FPS];
    int unsigned                 hist_pos;
    int unsigned                 hist_fill;
    longint unsigned             win_sum;
    longint unsigned             byte_total;
    longint unsigned             tick_total;
    longint unsigned             bps_avg;
    longint                      lag_acc;

    pacing_t         paced_frames [$];
    longint unsigned last_ticks = 64'd333333;
    int              frames_sent = 0;
    int              results_seen = 0;
    int              fault_count = 0;

    function automatic void pace_reset();
        fps_reg    = fsp_pkg::FPS_RESET;
        kbps_reg   = fsp_pkg::KBPS_RESET;
        foreach (size_hist[i])
        begin
            size_hist[i] = '0;
        end
        hist_pos   = 0;
        hist_fill  = 0;
        win_sum    = 0;
        byte_total = 0;
        tick_total = 0;
        bps_avg    = 0;
        lag_acc    = LAG_START;
    endfunction

    function automatic pacing_t pace_frame(input logic [fsp_pkg::BYTES_W-1:0] b,
                                           input logic [fsp_pkg::TICKS_W-1:0] t);
        int unsigned     f;
        longint unsigned kb;
        longint unsigned nominal;
        longint unsigned ftime;
        longint unsigned rate;
        logic [79:0]     bits_scaled;
        longint          lag;
        pacing_t         res;

        f = fps_reg;
        if (f == 0)
        begin
            f = 1;
        end
        if (f > fsp_pkg::MAX_FPS)
        begin
            f = fsp_pkg::MAX_FPS;
        end
        kb = (kbps_reg == '0) ? 64'd1 : 64'(kbps_reg);
        nominal = SEC_TICKS / f;

        if (hist_fill < f)
        begin
            hist_pos = hist_pos % fsp_pkg::MAX_FPS;
            size_hist[hist_pos] = b;
            hist_pos = hist_pos + 1;
            win_sum = win_sum + b;
            hist_fill = hist_fill + 1;
            ftime = nominal;
        end
        else
        begin
            hist_pos = hist_pos % f;
            win_sum = win_sum + b - size_hist[hist_pos];
            size_hist[hist_pos] = b;
            hist_pos = hist_pos + 1;
            ftime = (FRAME_SCALE * win_sum / f) / kb;
            if (ftime < nominal)
            begin
                ftime = nominal;
            end
        end
        if (ftime > FTIME_LIMIT)
        begin
            ftime = FTIME_LIMIT;
        end

        byte_total = byte_total + b;
        if (byte_total > ACC_LIMIT)
        begin
            byte_total = ACC_LIMIT;
        end
        tick_total = tick_total + t;
        if (tick_total > ACC_LIMIT)
        begin
            tick_total = ACC_LIMIT;
        end
        if (tick_total >= SEC_TICKS)
        begin
            bits_scaled = 80'(byte_total) * 80'(BIT_SCALE);
            rate = 64'(bits_scaled / 80'(tick_total));
            if (rate > RATE_LIMIT)
            begin
                rate = RATE_LIMIT;
            end
            bps_avg = (bps_avg * 3 + rate) / 4;
            byte_total = 0;
            tick_total = 0;
        end

        lag = lag_acc + longint'(ftime) - longint'({32'd0, t});
        if (lag > LAG_HI)
        begin
            lag = LAG_HI;
        end
        if (lag < LAG_LO)
        begin
            lag = LAG_LO;
        end
        lag_acc = lag;

        res.frame_ticks = ftime[fsp_pkg::FTIME_W-1:0];
        if (lag <= 0)
        begin
            res.send_delay = '0;
        end
        else if (lag > DELAY_LIMIT)
        begin
            res.send_delay = '1;
        end
        else
        begin
            res.send_delay = lag[fsp_pkg::DELAY_W-1:0];
        end
        res.measured_bps = bps_avg[fsp_pkg::BPS_W-1:0];
        return res;
    endfunction

    function automatic int draw_gap(input int n);
        if (((n / 40) % 3) == 2)
        begin
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    task automatic write_reg(input logic idx, input logic [fsp_pkg::CFG_W-1:0] value);
        frame_ch.valid <= 1'b0;
        while (paced_frames.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == fsp_pkg::CFG_FPS)
        begin
            fps_reg   = value[fsp_pkg::FPS_W-1:0];
            hist_pos  = 0;
            hist_fill = 0;
            win_sum   = 0;
        end
        else
        begin
            kbps_reg = value[fsp_pkg::KBPS_W-1:0];
        end
    endtask

    task automatic send_frame(input logic [fsp_pkg::BYTES_W-1:0] b,
                              input logic [fsp_pkg::TICKS_W-1:0] t,
                              input logic typed, input pacing_t given);
        int      gap;
        pacing_t calc;

        gap = draw_gap(frames_sent);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid         <= 1'b1;
        frame_ch.frame_bytes   <= b;
        frame_ch.elapsed_ticks <= t;
        do
        begin
            @(posedge clk);
        end
        while (!frame_ch.ready);
        calc = pace_frame(b, t);
        paced_frames.push_back(typed ? given : calc);
        last_ticks = calc.frame_ticks;
        frames_sent++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [fsp_pkg::KBPS_W-1:0]  kb;
        logic [fsp_pkg::BYTES_W-1:0] b;
        logic [fsp_pkg::TICKS_W-1:0] t;
        longint unsigned             span;
        int                          roll;

        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = fsp_pkg::CFG_FPS;
        cfg_data               = '0;
        frame_ch.valid         = 1'b0;
        frame_ch.frame_bytes   = '0;
        frame_ch.elapsed_ticks = '0;
        pace_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (SCRIPT[r])
        begin
            case (SCRIPT[r].kind)
                ROW_FPS:  write_reg(fsp_pkg::CFG_FPS, SCRIPT[r].value);
                ROW_KBPS: write_reg(fsp_pkg::CFG_KBPS, SCRIPT[r].value);
                default:  send_frame(SCRIPT[r].bytes, SCRIPT[r].ticks,
                                     SCRIPT[r].typed, SCRIPT[r].result);
            endcase
        end

        foreach (RUNS[p])
        begin
            write_reg(fsp_pkg::CFG_FPS, fsp_pkg::CFG_W'(RUNS[p].fps));
            kb = RUNS[p].kbps_random ? fsp_pkg::KBPS_W'($urandom_range(1, 1000000))
                                     : RUNS[p].kbps;
            write_reg(fsp_pkg::CFG_KBPS, fsp_pkg::CFG_W'(kb));
            for (int i = 0; i < RUNS[p].frames; i++)
            begin
                roll = $urandom_range(0, 15);
                if (roll == 0)
                begin
                    b = '0;
                end
                else if (roll == 1)
                begin
                    b = RUNS[p].bytes_hi;
                end
                else
                begin
                    b = fsp_pkg::BYTES_W'($urandom_range(RUNS[p].bytes_lo, RUNS[p].bytes_hi));
                end
                case (RUNS[p].law)
                    TICK_PACED:
                    begin
                        span = 2 * last_ticks;
                        if (span > 64'hFFFF_FFFF)
                        begin
                            span = 64'hFFFF_FFFF;
                        end
                        t = $urandom_range(0, 32'(span));
                    end
                    TICK_BURST:
                    begin
                        t = $urandom_range(0, 400000);
                    end
                    default:
                    begin
                        roll = $urandom_range(0, 15);
                        t = (roll == 0) ? '0 : (roll == 1) ? '1
                          : fsp_pkg::TICKS_W'($urandom());
                    end
                endcase
                send_frame(b, t, 1'b0, NO_RESULT);
            end
        end

        frame_ch.valid <= 1'b0;
        while (paced_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : pacing_sink
        int      gap;
        pacing_t got;
        pacing_t want;

        pacing_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(results_seen);
            if (results_seen == STALL_AT_A || results_seen == STALL_AT_B)
            begin
                gap = STALL_CYCLES;
            end
            if (gap > 0)
            begin
                pacing_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pacing_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pacing_ch.valid);
            got.frame_ticks  = pacing_ch.frame_ticks;
            got.send_delay   = pacing_ch.send_delay;
            got.measured_bps = pacing_ch.measured_bps;
            if (paced_frames.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("unexpected pacing item: frame_ticks %0d send_delay %0d bps %0d",
                             got.frame_ticks, got.send_delay, got.measured_bps);
                end
            end
            else
            begin
                want = paced_frames.pop_front();
                if (got.frame_ticks !== want.frame_ticks || got.send_delay !== want.send_delay ||
                    got.measured_bps !== want.measured_bps)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("pacing item %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                 results_seen, want.frame_ticks, want.send_delay,
                                 want.measured_bps, got.frame_ticks, got.send_delay,
                                 got.measured_bps);
                    end
                end
            end
            results_seen++;
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hdl/fsp_pkg.sv
hdl/fsp_if.sv
hdl/fsp_div.sv
hdl/frame_send_pacer.sv
bench/frame_send_pacer_tb.sv
